// File: rtl/core/literal_type_classifier_core_defines.svh
// assertion macros for the literal type classifier checker
// expects clk_i and rst_ni in the scope of each use
`ifndef LITERAL_TYPE_CLASSIFIER_CORE_DEFINES_SVH
`define LITERAL_TYPE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ltc_pkg.sv
// shared types and constants of the literal type classifier
// no dependencies
`timescale 1ns / 1ps

package ltc_pkg;

  // default number of stored head bytes
  localparam int HEAD_BYTES_DEF = 6;
  // head bytes the classifier looks at
  localparam int CLASS_BYTES = 5;
  // saturation value of the length counter
  localparam logic [2:0] LEN_MAX = 3'd7;
  localparam logic [1:0] CNT_MAX = 2'd3;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_THREE  = 8'h33;

  // pseudo literal spellings, first character in the top byte
  localparam logic [23:0] STR_NAN      = "nan";
  localparam logic [31:0] STR_NANF     = "nanf";
  localparam logic [31:0] STR_INF_NEG  = "-inf";
  localparam logic [31:0] STR_INF_POS  = "+inf";
  localparam logic [39:0] STR_INFF_NEG = "-inff";
  localparam logic [39:0] STR_INFF_POS = "+inff";

  // result codes
  typedef enum logic [3:0] {
    KIND_PLAIN         = 4'd0,
    KIND_ESCAPE        = 4'd1,
    KIND_HEX           = 4'd2,
    KIND_OCTAL         = 4'd3,
    KIND_INT           = 4'd4,
    KIND_FLOAT         = 4'd5,
    KIND_FLOAT_PSEUDO  = 4'd6,
    KIND_DOUBLE        = 4'd7,
    KIND_DOUBLE_PSEUDO = 4'd8,
    KIND_ERROR         = 4'd9
  } ltc_kind_e;

  // literal summary including the current character
  typedef struct packed {
    logic [CLASS_BYTES-1:0][7:0] head;
    logic [2:0]                  len;
    logic [1:0]                  dots;
    logic [1:0]                  fs;
    logic                        late_sign;
    logic                        digit;
    logic [2:0]                  bad;
    logic [7:0]                  cur_char;
  } ltc_summary_t;

endpackage

// File: rtl/core/ltc_track.sv
// per-literal summary registers of the literal type classifier
// depends on ltc_pkg
`timescale 1ns / 1ps

module ltc_track #(
  parameter int HEAD_BYTES = ltc_pkg::HEAD_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           char_i,
  input  logic                 final_i,
  output ltc_pkg::ltc_summary_t sum_o
);

  logic [HEAD_BYTES-1:0][7:0] head_q, head_d;
  logic [2:0] len_q, len_d;
  logic [1:0] dots_q, dots_d;
  logic [1:0] fs_q, fs_d;
  logic       late_q, late_d;
  logic       digit_q, digit_d;
  logic [2:0] bad_q, bad_d;
  logic       is_sign, is_dig;

  // character classes
  assign is_sign = (char_i == ltc_pkg::CH_PLUS) || (char_i == ltc_pkg::CH_MINUS);
  assign is_dig  = (char_i >= 8'h30) && (char_i <= 8'h39);

  // head bytes: write the character at its position while below the saturation point
  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if ((i < 7) && (len_q == 3'(i))) begin
        head_d[i] = char_i;
      end else begin
        head_d[i] = head_q[i];
      end
    end
  end

  // saturating counts and flags
  always_comb begin
    len_d   = (len_q == ltc_pkg::LEN_MAX) ? len_q : len_q + 3'd1;
    dots_d  = ((char_i == ltc_pkg::CH_DOT) && (dots_q != ltc_pkg::CNT_MAX)) ?
              dots_q + 2'd1 : dots_q;
    fs_d    = ((char_i == ltc_pkg::CH_F) && (fs_q != ltc_pkg::CNT_MAX)) ?
              fs_q + 2'd1 : fs_q;
    late_d  = late_q | (is_sign && (len_q != 3'd0));
    digit_d = digit_q | is_dig;
    bad_d   = bad_q;
    if (!is_sign && !is_dig) begin
      bad_d[0] = 1'b1;
      if ((char_i != ltc_pkg::CH_F) && (char_i != ltc_pkg::CH_DOT)) begin
        bad_d[1] = 1'b1;
      end
      if (char_i != ltc_pkg::CH_DOT) begin
        bad_d[2] = 1'b1;
      end
    end
  end

  // state registers, cleared after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      len_q   <= '0;
      dots_q  <= '0;
      fs_q    <= '0;
      late_q  <= 1'b0;
      digit_q <= 1'b0;
      bad_q   <= '0;
    end else if (step_i) begin
      if (final_i) begin
        head_q  <= '0;
        len_q   <= '0;
        dots_q  <= '0;
        fs_q    <= '0;
        late_q  <= 1'b0;
        digit_q <= 1'b0;
        bad_q   <= '0;
      end else begin
        head_q  <= head_d;
        len_q   <= len_d;
        dots_q  <= dots_d;
        fs_q    <= fs_d;
        late_q  <= late_d;
        digit_q <= digit_d;
        bad_q   <= bad_d;
      end
    end
  end

  // summary as seen after this character
  always_comb begin
    for (int i = 0; i < ltc_pkg::CLASS_BYTES; i++) begin
      sum_o.head[i] = head_d[i];
    end
    sum_o.len       = len_d;
    sum_o.dots      = dots_d;
    sum_o.fs        = fs_d;
    sum_o.late_sign = late_d;
    sum_o.digit     = digit_d;
    sum_o.bad       = bad_d;
    sum_o.cur_char  = char_i;
  end

endmodule

// File: rtl/core/ltc_classify.sv
// classification logic of the literal type classifier
// depends on ltc_pkg
`timescale 1ns / 1ps

module ltc_classify (
  input  ltc_pkg::ltc_summary_t sum_i,
  output ltc_pkg::ltc_kind_e    kind_o
);

  logic [7:0] h0, h1, h2, h3, h4;
  logic       quoted, esc2, hex3, hex4, oct2, oct3, oct4;
  logic       hex_ok, oct_ok;
  logic       has_dot, has_f, is_nan, fpseudo, dpseudo;

  assign h0 = sum_i.head[0];
  assign h1 = sum_i.head[1];
  assign h2 = sum_i.head[2];
  assign h3 = sum_i.head[3];
  assign h4 = sum_i.head[4];

  // byte classes of the head
  assign esc2 = h2 inside {"a", "b", "f", "n", "r", "t", "v", "'", "\"", "?", "\\"};
  assign hex3 = h3 inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  assign hex4 = h4 inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  assign oct2 = h2 inside {[8'h30:8'h37]};
  assign oct3 = h3 inside {[8'h30:8'h37]};
  assign oct4 = h4 inside {[8'h30:8'h37]};

  // quoted literal checks by length
  assign quoted = (h0 == ltc_pkg::CH_QUOTE) && (sum_i.cur_char == ltc_pkg::CH_QUOTE) &&
                  (sum_i.len > 3'd2);
  assign hex_ok = (sum_i.len == 3'd5) ? hex3 : (hex3 && hex4);
  always_comb begin
    case (sum_i.len)
      3'd4:    oct_ok = oct2;
      3'd5:    oct_ok = oct2 && oct3;
      3'd6:    oct_ok = oct2 && oct3 && oct4 && (h2 <= ltc_pkg::CH_THREE);
      default: oct_ok = 1'b0;
    endcase
  end

  // number and pseudo literal checks
  assign has_dot = sum_i.dots != 2'd0;
  assign has_f   = sum_i.fs != 2'd0;
  assign is_nan  = (sum_i.len == 3'd3) && ({h0, h1, h2} == ltc_pkg::STR_NAN);
  assign fpseudo = ((sum_i.len == 3'd5) && (({h0, h1, h2, h3, h4} == ltc_pkg::STR_INFF_NEG) ||
                                            ({h0, h1, h2, h3, h4} == ltc_pkg::STR_INFF_POS))) ||
                   ((sum_i.len == 3'd4) && ({h0, h1, h2, h3} == ltc_pkg::STR_NANF));
  assign dpseudo = ((sum_i.len == 3'd4) && (({h0, h1, h2, h3} == ltc_pkg::STR_INF_NEG) ||
                                            ({h0, h1, h2, h3} == ltc_pkg::STR_INF_POS))) ||
                   is_nan;

  // decision
  always_comb begin
    kind_o = ltc_pkg::KIND_ERROR;
    if (quoted) begin
      if (sum_i.len == 3'd3) begin
        kind_o = (h1 != ltc_pkg::CH_BSLASH) ? ltc_pkg::KIND_PLAIN : ltc_pkg::KIND_ERROR;
      end else if (h1 != ltc_pkg::CH_BSLASH) begin
        kind_o = ltc_pkg::KIND_ERROR;
      end else if ((sum_i.len == 3'd4) && esc2) begin
        kind_o = ltc_pkg::KIND_ESCAPE;
      end else if (sum_i.len == ltc_pkg::LEN_MAX) begin
        kind_o = ltc_pkg::KIND_ERROR;
      end else if (h2 == ltc_pkg::CH_X) begin
        kind_o = ((sum_i.len != 3'd4) && hex_ok) ? ltc_pkg::KIND_HEX : ltc_pkg::KIND_ERROR;
      end else begin
        kind_o = oct_ok ? ltc_pkg::KIND_OCTAL : ltc_pkg::KIND_ERROR;
      end
    end else if (!has_dot && !has_f && !is_nan) begin
      kind_o = (sum_i.bad[0] || !sum_i.digit || sum_i.late_sign) ?
               ltc_pkg::KIND_ERROR : ltc_pkg::KIND_INT;
    end else if (fpseudo) begin
      kind_o = ltc_pkg::KIND_FLOAT_PSEUDO;
    end else if (has_f && !dpseudo) begin
      kind_o = (sum_i.bad[1] || !sum_i.digit || (sum_i.dots > 2'd1) || (sum_i.fs != 2'd1) ||
                sum_i.late_sign || (sum_i.cur_char != ltc_pkg::CH_F)) ?
               ltc_pkg::KIND_ERROR : ltc_pkg::KIND_FLOAT;
    end else if (dpseudo) begin
      kind_o = ltc_pkg::KIND_DOUBLE_PSEUDO;
    end else if (has_dot) begin
      kind_o = (sum_i.bad[2] || !sum_i.digit || (sum_i.dots > 2'd1) || sum_i.late_sign) ?
               ltc_pkg::KIND_ERROR : ltc_pkg::KIND_DOUBLE;
    end
  end

endmodule

// File: rtl/core/literal_type_classifier_core.sv
// top level of the literal type classifier: input register, tracker, classifier, result register
// depends on ltc_pkg, ltc_track and ltc_classify
`timescale 1ns / 1ps

// Takes one character of a literal per cycle on the slave stream, tlast on the
// final character, and gives one result item per literal with its kind code
// (plain char, escape, hex, octal, int, float, float pseudo, double, double
// pseudo, error). The sustained rate is one character per cycle unless a
// final character stalls. A character sits in the input register, where the
// summary update and the classification are done in a single pass, and the
// kind lands in the result register, from which the result is shown.
// While a result waits, characters that are not final keep flowing; only a
// second final character stalls until the waiting result is taken. No clearing
// pass is needed after reset.
module literal_type_classifier_core #(
  parameter int HEAD_BYTES = ltc_pkg::HEAD_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // is_final
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] literal_kind, [7:4] zero
);

  logic                  in_valid_q;
  logic [7:0]            in_char_q;
  logic                  in_last_q;
  logic                  out_valid_q;
  ltc_pkg::ltc_kind_e    out_kind_q;
  logic                  advance;
  ltc_pkg::ltc_summary_t summary;
  ltc_pkg::ltc_kind_e    kind;

  // the held item moves on unless it needs the result slot and the slot is busy
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // summary state
  ltc_track #(
    .HEAD_BYTES(HEAD_BYTES)
  ) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .char_i (in_char_q),
    .final_i(in_last_q),
    .sum_o  (summary)
  );

  // kind of the literal ending here
  ltc_classify u_classify (
    .sum_i (summary),
    .kind_o(kind)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_kind_q <= kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_kind_q};

endmodule

// File: rtl/core/ltc_checker.sv
// port-level checker for the literal type classifier, bound to the top level
// depends on ltc_pkg and literal_type_classifier_core_defines.svh
`timescale 1ns / 1ps
`include "literal_type_classifier_core_defines.svh"

module ltc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic [3:0] out_kind;
  logic       out_free;

  assign out_kind = m_axis_tdata[3:0];
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // a shown result is a defined kind with zero padding
  `LTC_ASSERT_IMP(a_kind_code, m_axis_tvalid,
    (m_axis_tdata[7:4] == 4'd0) && (out_kind <= 4'(ltc_pkg::KIND_ERROR)),
    "result item carries an undefined kind code")

  // the input side only stalls while a result waits and is not taken
  `LTC_ASSERT_IMP(a_no_idle_stall, out_free, s_axis_tready,
    "input stalled while the result slot is free")

  // a stalled result holds
  `LTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata),
    "result item changed while stalled")

endmodule

bind literal_type_classifier_core ltc_checker u_ltc_checker (.*);
